// ===== design/tpc_pkg.sv =====
`timescale 1ns / 1ps

package tpc_pkg;

  // cache geometry
  localparam int SETS     = 64;
  localparam int SET_BITS = 6;
  localparam int WAYS     = 8;
  localparam int WAY_BITS = 3;
  // tree levels, floor(log2(WAYS)), and node count of the full tree
  localparam int LEVELS   = 3;
  localparam int NODES    = 7;

  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_HIT_PF  = 2'd1,
    OUT_MISS    = 2'd2,
    OUT_MISS_PF = 2'd3
  } outcome_t;

  // tag match result for one set
  typedef struct packed {
    logic                hit;
    logic [WAY_BITS-1:0] way;
  } match_t;

  // follow the node bits from the root down to the victim way
  function automatic logic [WAY_BITS-1:0] tree_victim(logic [NODES-1:0] tree);
    logic [LEVELS:0]     node;
    logic [WAY_BITS-1:0] w;
    logic                b;
    node = '0;
    w    = '0;
    for (int i = 0; i < LEVELS; i++) begin
      b    = tree[node[LEVELS-1:0]];
      w    = {w[WAY_BITS-2:0], b};
      node = (node << 1) + (LEVELS+1)'(1) + (LEVELS+1)'(b);
    end
    return w;
  endfunction

  // set every node on the path to way w so it points away from w
  function automatic logic [NODES-1:0] point_away(logic [NODES-1:0] tree,
                                                  logic [WAY_BITS-1:0] w);
    logic [LEVELS:0]  node;
    logic [NODES-1:0] t;
    logic             dir;
    node = '0;
    t    = tree;
    for (int i = 0; i < LEVELS; i++) begin
      dir                  = w[LEVELS-1-i];
      t[node[LEVELS-1:0]]  = ~dir;
      node = (node << 1) + (LEVELS+1)'(1) + (LEVELS+1)'(dir);
    end
    return t;
  endfunction

endpackage

// ===== design/tree_plru_cache_lookup.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake          ports
// ------------------------------------------------------------------------
// access    in         start & !busy      line_number, is_prefetch
// result    out        done (one cycle)   outcome, way_index, set_index
//
// An item is taken at the edge where start is high and busy is low, and the
// set's row read is issued there. In S_READ the tags are compared against the
// row, in S_UPDATE the row is updated and written back, and done is registered
// as S_UPDATE ends. busy is high in S_READ and S_UPDATE, so no new item is
// taken until the last one has written its row back; the receiver cannot stall
// the result. rst is synchronous and clears the per-set row-valid flags, so
// every set reads as empty with a zero tree after reset.

module tree_plru_cache_lookup
  import tpc_pkg::*;
#(
  parameter int LINE_BITS = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [47:0]         line_number,
  input  logic                is_prefetch,
  output logic                done,
  output logic [1:0]          outcome,
  output logic [2:0]          way_index,
  output logic [5:0]          set_index
);

  localparam int TAG_W  = LINE_BITS - SET_BITS;
  localparam int TAGS_W = WAYS * TAG_W;
  localparam int VLD_LO = TAGS_W;
  localparam int PF_LO  = TAGS_W + WAYS;
  localparam int TRE_LO = TAGS_W + 2 * WAYS;
  localparam int ROW_W  = TAGS_W + 2 * WAYS + NODES;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_UPDATE
  } state_t;

  state_t              state;
  logic [SETS-1:0]     row_valid;
  logic [SET_BITS-1:0] set_idx;
  logic [TAG_W-1:0]    tag;
  logic                pf_flag;
  logic [ROW_W-1:0]    row;
  match_t              match;

  logic                accept;
  logic [63:0]         line_ext;
  logic [ROW_W-1:0]    rd_row;
  logic [ROW_W-1:0]    rd_row_live;
  match_t              rd_match;

  logic [WAY_BITS-1:0] way;
  outcome_t            outcome_next;
  logic [ROW_W-1:0]    row_next;

  assign accept   = start && (state == S_IDLE);
  assign busy     = (state != S_IDLE);
  assign line_ext = 64'(line_number);

  // per-set row memory: tags, valid bits, prefetch marks, tree bits
  tpc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (state == S_UPDATE),
    .waddr (set_idx),
    .wdata (row_next),
    .re    (accept),
    .raddr (line_number[SET_BITS-1:0]),
    .rdata (rd_row)
  );

  // a row never written reads as empty with a zero tree
  always_comb begin
    rd_row_live = rd_row;
    if (!row_valid[set_idx]) begin
      rd_row_live[ROW_W-1:TAGS_W] = '0;
    end
  end

  tpc_match #(
    .TAG_W (TAG_W)
  ) u_match (
    .tags  (rd_row_live[TAGS_W-1:0]),
    .valid (rd_row_live[VLD_LO +: WAYS]),
    .tag   (tag),
    .match (rd_match)
  );

  // pick the way, classify the item and build the updated row
  always_comb begin
    logic [WAYS-1:0]  vld;
    logic [WAYS-1:0]  pf;
    logic [NODES-1:0] tree;
    vld      = row[VLD_LO +: WAYS];
    pf       = row[PF_LO +: WAYS];
    tree     = row[TRE_LO +: NODES];
    row_next = row;
    if (match.hit) begin
      way          = match.way;
      outcome_next = pf[way] ? OUT_HIT_PF : OUT_HIT;
      pf[way]      = 1'b0;
    end else begin
      way          = tree_victim(tree);
      outcome_next = (vld[way] && pf[way]) ? OUT_MISS_PF : OUT_MISS;
      pf[way]      = pf_flag;
      vld[way]     = 1'b1;
      row_next[way*TAG_W +: TAG_W] = tag;
    end
    row_next[VLD_LO +: WAYS]  = vld;
    row_next[PF_LO +: WAYS]   = pf;
    row_next[TRE_LO +: NODES] = point_away(tree, way);
  end

  // sequencer, item registers and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_valid <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            set_idx <= line_number[SET_BITS-1:0];
            tag     <= line_ext[LINE_BITS-1:SET_BITS];
            pf_flag <= is_prefetch;
            state   <= S_READ;
          end
        end
        S_READ: begin
          row   <= rd_row_live;
          match <= rd_match;
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          row_valid[set_idx] <= 1'b1;
          done               <= 1'b1;
          outcome            <= outcome_next;
          way_index          <= 3'(way);
          set_index          <= 6'(set_idx);
          state              <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/tpc_ram.sv =====
`timescale 1ns / 1ps

module tpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tpc_match.sv =====
`timescale 1ns / 1ps

module tpc_match
  import tpc_pkg::*;
#(
  parameter int TAG_W = 42
) (
  input  logic [WAYS*TAG_W-1:0] tags,
  input  logic [WAYS-1:0]       valid,
  input  logic [TAG_W-1:0]      tag,
  output match_t                match
);

  // compare all ways at once, lowest matching way wins
  always_comb begin
    match = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid[w] && tags[w*TAG_W +: TAG_W] == tag) begin
        match.hit = 1'b1;
        match.way = WAY_BITS'(w);
      end
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int TAG_BITS       = 48 - SET_BITS;

  // one expected lookup result
  typedef struct {
    outcome_t            outcome;
    logic [WAY_BITS-1:0] way;
    logic [SET_BITS-1:0] set;
  } lookup_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [47:0] line_number = '0;
  logic        is_prefetch = 1'b0;
  logic        done;
  logic [1:0]  outcome;
  logic [2:0]  way_index;
  logic [5:0]  set_index;

  // shadow copy of the cache contents
  logic [TAG_BITS-1:0] shadow_tag   [SETS][WAYS];
  logic                shadow_valid [SETS][WAYS];
  logic                shadow_pf    [SETS][WAYS];
  logic [NODES-1:0]    shadow_tree  [SETS];

  lookup_result_t pending_results[$];
  lookup_result_t head_res;
  int             mismatch_count = 0;
  int             quiet_cycles = 0;

  tree_plru_cache_lookup u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .line_number (line_number),
    .is_prefetch (is_prefetch),
    .done        (done),
    .outcome     (outcome),
    .way_index   (way_index),
    .set_index   (set_index)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mark every node on the path to a way so that it points at the other half
  function automatic logic [NODES-1:0] steer_from_way(logic [NODES-1:0] tree,
                                                      logic [WAY_BITS-1:0] way);
    int   node;
    logic half;
    node = 0;
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      half       = way[LEVELS-1-lvl];
      tree[node] = !half;
      node       = 2 * node + 1 + int'(half);
    end
    return tree;
  endfunction

  // look one access up in the shadow cache and update it
  task automatic plru_lookup(input logic [47:0] line, input logic pf,
                             output lookup_result_t res);
    logic [SET_BITS-1:0] set;
    logic [TAG_BITS-1:0] tag;
    logic [WAY_BITS-1:0] way;
    logic                hit;
    logic                bit_val;
    int                  node;
    set = line[SET_BITS-1:0];
    tag = line[47:SET_BITS];
    hit = 1'b0;
    way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && shadow_valid[set][w] && shadow_tag[set][w] == tag) begin
        hit = 1'b1;
        way = WAY_BITS'(w);
      end
    end
    if (hit) begin
      res.outcome = shadow_pf[set][way] ? OUT_HIT_PF : OUT_HIT;
      shadow_pf[set][way] = 1'b0;
    end else begin
      // walk the tree from the root to the victim, empty ways get no priority
      node = 0;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
        bit_val = shadow_tree[set][node];
        way     = {way[WAY_BITS-2:0], bit_val};
        node    = 2 * node + 1 + int'(bit_val);
      end
      res.outcome = (shadow_valid[set][way] && shadow_pf[set][way]) ? OUT_MISS_PF
                                                                    : OUT_MISS;
      shadow_tag[set][way]   = tag;
      shadow_valid[set][way] = 1'b1;
      shadow_pf[set][way]    = pf;
    end
    shadow_tree[set] = steer_from_way(shadow_tree[set], way);
    res.way = way;
    res.set = set;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // drive one access, wait for it to be taken, then queue its expected result
  task automatic send_access(input logic [47:0] line, input logic pf,
                             input int idle_pct);
    lookup_result_t res;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    line_number <= line;
    is_prefetch <= pf;
    do @(posedge clk); while (busy);
    plru_lookup(line, pf, res);
    pending_results.push_back(res);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, way", way_index, 0);
      end else begin
        head_res = pending_results.pop_front();
        if (outcome !== head_res.outcome)
          report_mismatch("outcome", outcome, head_res.outcome);
        if (way_index !== head_res.way)
          report_mismatch("way_index", way_index, head_res.way);
        if (set_index !== head_res.set)
          report_mismatch("set_index", set_index, head_res.set);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // extremes of the line number, prefetch marks and eviction of unused prefetches
  task automatic test_corner_lines();
    send_access(48'h0, 1'b0, 0);
    send_access(48'h0, 1'b0, 0);
    send_access(48'h0, 1'b1, 0);
    send_access(48'hFFFF_FFFF_FFFF, 1'b1, 0);
    send_access(48'hFFFF_FFFF_FFFF, 1'b0, 0);
    send_access(48'hFFFF_FFFF_FFFF, 1'b0, 0);
    send_access(48'hAAAA_AAAA_AAAA, 1'b0, 0);
    send_access(48'h5555_5555_5555, 1'b1, 0);
    // fill set 5 with prefetches, then overflow it
    for (int t = 1; t <= 8; t++)
      send_access({TAG_BITS'(t), 6'd5}, 1'b1, 0);
    send_access({TAG_BITS'(9), 6'd5}, 1'b0, 0);
    send_access({TAG_BITS'(9), 6'd5}, 1'b0, 0);
    send_access({TAG_BITS'(4), 6'd5}, 1'b0, 0);
    send_access({TAG_BITS'(10), 6'd5}, 1'b0, 0);
    send_access({TAG_BITS'(11), 6'd5}, 1'b1, 0);
    send_access({TAG_BITS'(10), 6'd5}, 1'b1, 0);
  endtask

  // a few sets hammered with more tags than ways
  task automatic test_eviction_pressure(input int idle_pct, input int count);
    logic [SET_BITS-1:0] hot_sets [4];
    logic [TAG_BITS-1:0] tag_pool [12];
    for (int i = 0; i < 4; i++) hot_sets[i] = SET_BITS'($urandom);
    for (int i = 0; i < 12; i++) tag_pool[i] = TAG_BITS'({$urandom, $urandom});
    for (int n = 0; n < count; n++)
      send_access({tag_pool[$urandom_range(11)], hot_sets[$urandom_range(3)]},
                  $urandom_range(2) == 0, idle_pct);
  endtask

  // reuse of recent lines mixed with fresh random lines
  task automatic test_reuse_mix(input int idle_pct, input int count);
    logic [47:0] recent [32];
    logic [47:0] line;
    int          fill;
    int          wr;
    fill = 0;
    wr   = 0;
    for (int n = 0; n < count; n++) begin
      if (fill > 0 && $urandom_range(99) < 55) begin
        line = recent[$urandom_range(fill - 1)];
      end else begin
        line = 48'({$urandom, $urandom});
        if ($urandom_range(3) == 0) line[SET_BITS-1:0] = SET_BITS'($urandom_range(3));
        recent[wr] = line;
        wr = (wr + 1) % 32;
        if (fill < 32) fill++;
      end
      send_access(line, $urandom_range(3) == 0, idle_pct);
    end
  endtask

  initial begin
    int idle_phases [3];
    idle_phases = '{0, 54, 11};
    for (int s = 0; s < SETS; s++) begin
      shadow_tree[s] = '0;
      for (int w = 0; w < WAYS; w++) begin
        shadow_tag[s][w]   = '0;
        shadow_valid[s][w] = 1'b0;
        shadow_pf[s][w]    = 1'b0;
      end
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_lines();
    foreach (idle_phases[p]) begin
      test_eviction_pressure(idle_phases[p], 100);
      test_reuse_mix(idle_phases[p], 150);
    end

    // let the last results come out
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tpc_pkg.sv
design/tpc_ram.sv
design/tpc_match.sv
design/tree_plru_cache_lookup.sv
bench/tb_top.sv
